FILE: src/qte_pkg.sv
// Shared constants and tables for the quaternion to Euler angle converter.
package qte_pkg;

    // working scale: 1.0 is 2^WORK_BITS
    localparam int WORK_BITS  = 28;
    // clamped pitch term spans -1.0..+1.0 inclusive
    localparam int SP_W       = WORK_BITS + 2;
    localparam int SQRT_STEPS = WORK_BITS + 1;
    // square, radicand, then one root bit per stage
    localparam int ISQRT_LAT  = SQRT_STEPS + 2;

    // angle accumulator: hundredths of a degree times 2^16
    localparam int ANG_W    = 34;
    localparam int ATAN_LEN = 24;
    localparam logic signed [ANG_W-1:0] ANG_180 = 34'sd1179648000;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [ATAN_LEN] = '{
        34'sd294912000, 34'sd174096719, 34'sd91987925, 34'sd46694507,
        34'sd23437865,  34'sd11730358,  34'sd5866610,  34'sd2933484,
        34'sd1466764,   34'sd733385,    34'sd366693,   34'sd183346,
        34'sd91673,     34'sd45837,     34'sd22918,    34'sd11459,
        34'sd5730,      34'sd2865,      34'sd1432,     34'sd716,
        34'sd358,       34'sd179,       34'sd90,       34'sd45
    };

    localparam int RND_W = ANG_W - 15;
    localparam logic signed [RND_W-1:0] ROLL_LIM  = 19'sd18000;
    localparam logic signed [RND_W-1:0] PITCH_LIM = 19'sd9000;
    localparam logic signed [RND_W-1:0] YAW_WRAP  = 19'sd36000;

endpackage

FILE: src/qte_prod.sv
// Product stage and sum stage: builds the atan2 operands at working scale.
module qte_prod #(
    parameter int QUAT_FRAC_BITS = 15,
    parameter int WK_W           = 32
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [15:0]                quat_w,
    input  logic signed [15:0]                quat_x,
    input  logic signed [15:0]                quat_y,
    input  logic signed [15:0]                quat_z,
    output logic signed [WK_W-1:0]            sr,
    output logic signed [WK_W-1:0]            cr,
    output logic signed [WK_W-1:0]            sy,
    output logic signed [WK_W-1:0]            cy,
    output logic signed [qte_pkg::SP_W-1:0]   sp
);
    localparam int TWO_F = 2 * QUAT_FRAC_BITS;
    localparam int SUM_W = (TWO_F + 2 > 34) ? TWO_F + 2 : 34;
    localparam int SH    = (TWO_F >= qte_pkg::WORK_BITS) ? TWO_F - qte_pkg::WORK_BITS : 0;
    localparam int SHL   = (TWO_F >= qte_pkg::WORK_BITS) ? 0 : qte_pkg::WORK_BITS - TWO_F;
    localparam logic signed [SUM_W-1:0] ONE = {{(SUM_W-1){1'b0}}, 1'b1} << TWO_F;
    localparam logic signed [SUM_W-1:0] NEG_ONE = -ONE;

    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] wy_reg, zx_reg, wz_reg, xy_reg;
    logic signed [SUM_W-1:0] sr_s, cr_s, sy_s, cy_s, sp_s, spc_s;
    logic signed [WK_W-1:0] sr_next, cr_next, sy_next, cy_next, sp_wk;
    logic signed [WK_W-1:0] sr_reg, cr_reg, sy_reg, cy_reg;
    logic signed [qte_pkg::SP_W-1:0] sp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            wy_reg <= quat_w * quat_y;
            zx_reg <= quat_z * quat_x;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
        end
    end

    always_comb
    begin
        sr_s = (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
        cr_s = ONE - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
        sy_s = (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
        cy_s = ONE - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);
        sp_s = (SUM_W'(wy_reg) - SUM_W'(zx_reg)) <<< 1;
        if (sp_s > ONE)
            spc_s = ONE;
        else if (sp_s < NEG_ONE)
            spc_s = NEG_ONE;
        else
            spc_s = sp_s;
    end

    // rescale to working scale: floor shift right or zero fill left
    generate
        if (TWO_F >= qte_pkg::WORK_BITS)
        begin : g_shr
            assign sr_next = sr_s[SUM_W-1:SH];
            assign cr_next = cr_s[SUM_W-1:SH];
            assign sy_next = sy_s[SUM_W-1:SH];
            assign cy_next = cy_s[SUM_W-1:SH];
            assign sp_wk   = spc_s[SUM_W-1:SH];
        end
        else
        begin : g_shl
            assign sr_next = {sr_s, {SHL{1'b0}}};
            assign cr_next = {cr_s, {SHL{1'b0}}};
            assign sy_next = {sy_s, {SHL{1'b0}}};
            assign cy_next = {cy_s, {SHL{1'b0}}};
            assign sp_wk   = {spc_s, {SHL{1'b0}}};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_reg <= sr_next;
            cr_reg <= cr_next;
            sy_reg <= sy_next;
            cy_reg <= cy_next;
            sp_reg <= sp_wk[qte_pkg::SP_W-1:0];
        end
    end

    assign sr = sr_reg;
    assign cr = cr_reg;
    assign sy = sy_reg;
    assign cy = cy_reg;
    assign sp = sp_reg;

endmodule

FILE: src/qte_isqrt.sv
// Pipelined floor square root of 1 - sp^2 at working scale, one root bit per stage.
module qte_isqrt (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [qte_pkg::SP_W-1:0]   sp,
    output logic [qte_pkg::SP_W-1:0]          root
);
    localparam int RAD_W = 2 * qte_pkg::WORK_BITS + 1;
    localparam int RES_W = RAD_W + 1;
    localparam int N     = qte_pkg::SQRT_STEPS;
    localparam logic [RAD_W-1:0] FULL = {1'b1, {(RAD_W-1){1'b0}}};

    logic signed [2*qte_pkg::SP_W-1:0] sq_full;
    logic [RAD_W-1:0] sq_reg;
    logic [RAD_W-1:0] v_reg   [0:N];
    logic [RES_W-1:0] res_reg [0:N];

    assign sq_full = sp * sp;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg     <= sq_full[RAD_W-1:0];
            v_reg[0]   <= FULL - sq_reg;
            res_reg[0] <= '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_step
            localparam logic [RES_W-1:0] BIT = {{(RES_W-1){1'b0}}, 1'b1} << (2 * (N - 1 - k));
            logic [RES_W-1:0] trial;
            logic             take;
            assign trial = res_reg[k] + BIT;
            assign take  = ({1'b0, v_reg[k]} >= trial);
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (take)
                    begin
                        v_reg[k+1]   <= v_reg[k] - trial[RAD_W-1:0];
                        res_reg[k+1] <= (res_reg[k] >> 1) + BIT;
                    end
                    else
                    begin
                        v_reg[k+1]   <= v_reg[k];
                        res_reg[k+1] <= res_reg[k] >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root = res_reg[N][qte_pkg::SP_W-1:0];

endmodule

FILE: src/qte_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(y, x) in centidegrees times 2^16.
module qte_cordic #(
    parameter int IN_W  = 32,
    parameter int STEPS = 16
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [IN_W-1:0]            x_in,
    input  logic signed [IN_W-1:0]            y_in,
    output logic signed [qte_pkg::ANG_W-1:0]  angle
);
    localparam int CW = IN_W + 2;

    logic signed [CW-1:0]             x_reg [0:STEPS];
    logic signed [CW-1:0]             y_reg [0:STEPS];
    logic signed [qte_pkg::ANG_W-1:0] z_reg [0:STEPS];
    logic                             zero_reg [0:STEPS];

    // left half plane: turn by 180 degrees first
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg[0] <= -CW'(x_in);
                y_reg[0] <= -CW'(y_in);
                z_reg[0] <= (y_in >= 0) ? qte_pkg::ANG_180 : -qte_pkg::ANG_180;
            end
            else
            begin
                x_reg[0] <= CW'(x_in);
                y_reg[0] <= CW'(y_in);
                z_reg[0] <= '0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < STEPS; i++)
        begin : g_iter
            logic signed [CW-1:0] xs, ys;
            assign xs = x_reg[i] >>> i;
            assign ys = y_reg[i] >>> i;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (y_reg[i] >= 0)
                    begin
                        x_reg[i+1] <= x_reg[i] + ys;
                        y_reg[i+1] <= y_reg[i] - xs;
                        z_reg[i+1] <= z_reg[i] + qte_pkg::ATAN_TAB[i];
                    end
                    else
                    begin
                        x_reg[i+1] <= x_reg[i] - ys;
                        y_reg[i+1] <= y_reg[i] + xs;
                        z_reg[i+1] <= z_reg[i] - qte_pkg::ATAN_TAB[i];
                    end
                end
            end
        end
    endgenerate

    assign angle = zero_reg[STEPS] ? '0 : z_reg[STEPS];

endmodule

FILE: src/quaternion_to_euler_angles.sv
// Quaternion (Q1.15) to ZYX Euler angles in centidegrees, fully pipelined.
// Pipeline order: product and sum stages, square root, CORDIC, then a rounding register.
// Throughput: one quaternion per cycle; the whole pipeline holds while a result is stalled.
// Reset (rst_n, asynchronous, active low) clears only the valid bits of the pipeline.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS   = 16,
    parameter int QUAT_FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        yaw_centideg,
    output logic signed [14:0] pitch_centideg,
    output logic signed [15:0] roll_centideg
);
    localparam int TWO_F = 2 * QUAT_FRAC_BITS;
    localparam int SUM_W = (TWO_F + 2 > 34) ? TWO_F + 2 : 34;
    localparam int WK_W  = (TWO_F >= qte_pkg::WORK_BITS) ?
                           SUM_W - (TWO_F - qte_pkg::WORK_BITS) :
                           SUM_W + (qte_pkg::WORK_BITS - TWO_F);
    localparam int DLY   = qte_pkg::ISQRT_LAT;
    localparam int LAT   = 2 + DLY + CORDIC_STEPS + 1 + 1;
    localparam int RW    = qte_pkg::RND_W;

    logic           en;
    logic [LAT-1:0] vld_reg;

    logic signed [WK_W-1:0]          sr, cr, sy, cy;
    logic signed [qte_pkg::SP_W-1:0] sp;
    logic [qte_pkg::SP_W-1:0]        root;

    logic signed [WK_W-1:0]          sr_d_reg [0:DLY-1];
    logic signed [WK_W-1:0]          cr_d_reg [0:DLY-1];
    logic signed [WK_W-1:0]          sy_d_reg [0:DLY-1];
    logic signed [WK_W-1:0]          cy_d_reg [0:DLY-1];
    logic signed [qte_pkg::SP_W-1:0] sp_d_reg [0:DLY-1];

    logic signed [qte_pkg::ANG_W-1:0] roll_ang, pitch_ang, yaw_ang;
    logic signed [qte_pkg::SP_W:0]    px, py;
    logic signed [RW-1:0] roll_s, pitch_s, yaw_s, yaw_w;
    logic [15:0]        yaw_reg;
    logic signed [14:0] pitch_reg;
    logic signed [15:0] roll_reg;

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    qte_prod #(
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .WK_W           (WK_W)
    ) u_prod (
        .clk    (clk),
        .en     (en),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z),
        .sr     (sr),
        .cr     (cr),
        .sy     (sy),
        .cy     (cy),
        .sp     (sp)
    );

    qte_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .sp   (sp),
        .root (root)
    );

    // hold the operands while the square root runs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sr_d_reg[0] <= sr;
            cr_d_reg[0] <= cr;
            sy_d_reg[0] <= sy;
            cy_d_reg[0] <= cy;
            sp_d_reg[0] <= sp;
            for (int k = 1; k < DLY; k++)
            begin
                sr_d_reg[k] <= sr_d_reg[k-1];
                cr_d_reg[k] <= cr_d_reg[k-1];
                sy_d_reg[k] <= sy_d_reg[k-1];
                cy_d_reg[k] <= cy_d_reg[k-1];
                sp_d_reg[k] <= sp_d_reg[k-1];
            end
        end
    end

    assign px = {1'b0, root};
    assign py = (qte_pkg::SP_W + 1)'(sp_d_reg[DLY-1]);

    qte_cordic #(.IN_W(WK_W), .STEPS(CORDIC_STEPS)) u_roll (
        .clk   (clk),
        .en    (en),
        .x_in  (cr_d_reg[DLY-1]),
        .y_in  (sr_d_reg[DLY-1]),
        .angle (roll_ang)
    );

    qte_cordic #(.IN_W(qte_pkg::SP_W + 1), .STEPS(CORDIC_STEPS)) u_pitch (
        .clk   (clk),
        .en    (en),
        .x_in  (px),
        .y_in  (py),
        .angle (pitch_ang)
    );

    qte_cordic #(.IN_W(WK_W), .STEPS(CORDIC_STEPS)) u_yaw (
        .clk   (clk),
        .en    (en),
        .x_in  (cy_d_reg[DLY-1]),
        .y_in  (sy_d_reg[DLY-1]),
        .angle (yaw_ang)
    );

    // round half up to centidegrees, then clamp to +-lim
    function automatic logic signed [RW-1:0] round_sat(
        input logic signed [qte_pkg::ANG_W-1:0] acc,
        input logic signed [RW-1:0]             lim
    );
        logic signed [qte_pkg::ANG_W:0] s;
        logic signed [RW-1:0]           r;
        s = (qte_pkg::ANG_W + 1)'(acc) + (qte_pkg::ANG_W + 1)'(32768);
        r = s[qte_pkg::ANG_W:16];
        if (r > lim)
            return lim;
        else if (r < -lim)
            return -lim;
        else
            return r;
    endfunction

    always_comb
    begin
        roll_s  = round_sat(roll_ang, qte_pkg::ROLL_LIM);
        pitch_s = round_sat(pitch_ang, qte_pkg::PITCH_LIM);
        yaw_s   = round_sat(yaw_ang, qte_pkg::ROLL_LIM);
        yaw_w   = (yaw_s < 0) ? yaw_s + qte_pkg::YAW_WRAP : yaw_s;
        if (yaw_w >= qte_pkg::YAW_WRAP)
            yaw_w = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_reg   <= yaw_w[15:0];
            pitch_reg <= pitch_s[14:0];
            roll_reg  <= roll_s[15:0];
        end
    end

    assign out_valid      = vld_reg[LAT-1];
    assign yaw_centideg   = yaw_reg;
    assign pitch_centideg = pitch_reg;
    assign roll_centideg  = roll_reg;

`ifndef NO_ASSERTIONS
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(vld_reg))
        else $error("pipeline moved during an output stall");
    a_yaw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (yaw_centideg < 16'd36000))
        else $error("yaw out of range");
    a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_centideg <= 15'sd9000 && pitch_centideg >= -15'sd9000))
        else $error("pitch out of range");
    a_roll: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll_centideg <= 16'sd18000 && roll_centideg >= -16'sd18000))
        else $error("roll out of range");
`endif

endmodule
